// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of the leaf probability block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/stlp_pkg.sv -----
// ----------------------------------------------------------------------------
// stlp_pkg
// Types, constants and the sigmoid table of the soft tree leaf probability block.
// ----------------------------------------------------------------------------
package stlp_pkg;

  localparam int MaxEntriesDef  = 64;
  localparam int MaxLeavesDef   = 32;
  localparam int MaxFeaturesDef = 64;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [1:0] CFG_INV_TAU     = 2'd0;
  localparam logic [1:0] CFG_NUM_ENTRIES = 2'd1;
  localparam logic [1:0] CFG_NUM_LEAVES  = 2'd2;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_FEATURE = 1'b1;

  typedef struct packed {
    logic [4:0]         slot;
    logic signed [15:0] split;
    logic               left;
    logic [5:0]         feat;
  } anc_t;

  typedef struct packed {
    logic               vld;
    logic signed [16:0] d;
    logic               left;
  } sig_req_t;

  typedef struct packed {
    logic        vld;
    logic [16:0] p;
  } sig_rsp_t;

  function automatic logic [15:0] sig_tab(input logic [3:0] k);
    logic [15:0] v;
    case (k)
      4'd0:    v = 16'd32768;
      4'd1:    v = 16'd47911;
      4'd2:    v = 16'd57724;
      4'd3:    v = 16'd62428;
      4'd4:    v = 16'd64357;
      4'd5:    v = 16'd65097;
      4'd6:    v = 16'd65374;
      4'd7:    v = 16'd65476;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/stlp_in_if.sv -----
// ----------------------------------------------------------------------------
// stlp_in_if
// Input channel: ancestor entry loads and feature values.
// ----------------------------------------------------------------------------
interface stlp_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [5:0]         entry_index;
  logic [4:0]         leaf_slot;
  logic signed [15:0] split_value;
  logic               goes_left;
  logic [5:0]         split_feature;
  logic [5:0]         feature_index;
  logic signed [15:0] feature_value;
  logic               last_feature;

  modport source (output valid, mode, entry_index, leaf_slot, split_value, goes_left,
                  split_feature, feature_index, feature_value, last_feature,
                  input ready);
  modport sink (input valid, mode, entry_index, leaf_slot, split_value, goes_left,
                split_feature, feature_index, feature_value, last_feature,
                output ready);
endinterface

// ----- rtl/stlp_out_if.sv -----
// ----------------------------------------------------------------------------
// stlp_out_if
// Result channel: one leaf probability per transfer.
// ----------------------------------------------------------------------------
interface stlp_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  leaf_index;
  logic [16:0] leaf_probability;
  logic        last_leaf;

  modport source (output valid, leaf_index, leaf_probability, last_leaf, input ready);
  modport sink (input valid, leaf_index, leaf_probability, last_leaf, output ready);
endinterface

// ----- rtl/soft_tree_leaf_probabilities.sv -----
// ----------------------------------------------------------------------------
// soft_tree_leaf_probabilities
// Soft decision tree routing: per-leaf products of sigmoid branch probabilities.
// ----------------------------------------------------------------------------
// The feature item marked last starts a row: the block walks the ancestor
// table one entry at a time (ancestor read, feature read, difference, the
// three-stage sigmoid unit, then, for a leaf slot in range, a read, multiply
// and write back of the leaf product memory), and then emits the leaves one
// at a time from the leaf product memory, waiting while a result is unsent.
// No input is taken during the row walk and emission.
// Ancestor entries and features are held in single-port memories; leaf
// products carry one valid bit per leaf that is cleared at each row start.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module soft_tree_leaf_probabilities
  import stlp_pkg::*;
#(
  parameter int MAX_ENTRIES  = MaxEntriesDef,
  parameter int MAX_LEAVES   = MaxLeavesDef,
  parameter int MAX_FEATURES = MaxFeaturesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  stlp_in_if.sink     in_ch,
  stlp_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int EAW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int FAW      = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int LAW      = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
  localparam int LEAF_CAP = (MAX_LEAVES < 32) ? MAX_LEAVES : 32;

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b0000000001,
    ST_ANC_RD    = 10'b0000000010,
    ST_FEAT_RD   = 10'b0000000100,
    ST_DIFF      = 10'b0000001000,
    ST_SIG_GO    = 10'b0000010000,
    ST_SIG_WAIT  = 10'b0000100000,
    ST_LEAF_RD   = 10'b0001000000,
    ST_LEAF_MUL  = 10'b0010000000,
    ST_LEAF_WR   = 10'b0100000000,
    ST_EMIT_RD   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   emit_wait_r, emit_wait_nxt;

  logic [15:0] inv_tau_r;
  logic [6:0]  num_entries_r;
  logic [5:0]  num_leaves_r;

  logic [6:0]  n_ent_r, n_ent_nxt;
  logic [5:0]  n_leaf_r, n_leaf_nxt;
  logic [6:0]  ent_r, ent_nxt;
  logic [5:0]  leaf_r, leaf_nxt;

  anc_t               anc_mem [MAX_ENTRIES];
  logic signed [15:0] feat_mem [MAX_FEATURES];
  logic [16:0]        leaf_mem [MAX_LEAVES];
  logic [MAX_LEAVES-1:0] leaf_vld_r;

  anc_t               anc_q;
  logic signed [15:0] feat_q;
  logic               feat_ok_r;
  logic [16:0]        leaf_q;
  logic               leaf_q_vld;
  logic signed [16:0] d_r;
  logic [16:0]        p_r;
  logic [33:0]        prod_r;

  logic        out_vld_r;
  logic [4:0]  out_idx_r;
  logic [16:0] out_prob_r;
  logic        out_last_r;

  sig_req_t sig_req;
  sig_rsp_t sig_rsp;

  logic in_xfer, row_start, out_free, slot_ok, leaf_wr;
  logic [6:0] ent_inc;
  logic [16:0] leaf_new;
  logic signed [16:0] x_ext;

  assign in_ch.ready = (state_r == ST_IDLE) && !emit_wait_r;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign row_start   = in_xfer && (in_ch.mode == MODE_FEATURE) && in_ch.last_feature;
  assign out_free    = !out_vld_r || out_ch.ready;
  assign slot_ok     = 32'(anc_q.slot) < MAX_LEAVES;
  assign leaf_wr     = (state_r == ST_LEAF_WR);
  assign ent_inc     = ent_r + 7'd1;
  assign leaf_new    = 17'((prod_r + 34'd32768) >> 16);
  assign x_ext       = feat_ok_r ? 17'(feat_q) : 17'sd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_tau_r     <= 16'd256;
      num_entries_r <= 7'd1;
      num_leaves_r  <= 6'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_TAU:     inv_tau_r     <= cfg_data;
        CFG_NUM_ENTRIES: num_entries_r <= cfg_data[6:0];
        CFG_NUM_LEAVES:  num_leaves_r  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (in_ch.mode == MODE_LOAD) && (32'(in_ch.entry_index) < MAX_ENTRIES)) begin
      anc_mem[EAW'(in_ch.entry_index)] <= '{slot: in_ch.leaf_slot, split: in_ch.split_value,
                                           left: in_ch.goes_left, feat: in_ch.split_feature};
    end
    if (state_r == ST_ANC_RD) begin
      anc_q <= anc_mem[EAW'(ent_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (in_ch.mode == MODE_FEATURE) &&
        (32'(in_ch.feature_index) < MAX_FEATURES)) begin
      feat_mem[FAW'(in_ch.feature_index)] <= in_ch.feature_value;
    end
    if (state_r == ST_FEAT_RD) begin
      feat_q    <= feat_mem[FAW'(anc_q.feat)];
      feat_ok_r <= 32'(anc_q.feat) < MAX_FEATURES;
    end
  end

  always_ff @(posedge clk) begin
    if (leaf_wr) begin
      leaf_mem[LAW'(anc_q.slot)] <= leaf_new;
    end
    if (state_r == ST_LEAF_RD) begin
      leaf_q     <= leaf_mem[LAW'(anc_q.slot)];
      leaf_q_vld <= leaf_vld_r[LAW'(anc_q.slot)];
    end else if (state_r == ST_EMIT_RD) begin
      leaf_q     <= leaf_mem[LAW'(leaf_r)];
      leaf_q_vld <= leaf_vld_r[LAW'(leaf_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_vld_r <= '0;
    end else if (row_start) begin
      leaf_vld_r <= '0;
    end else if (leaf_wr) begin
      leaf_vld_r[LAW'(anc_q.slot)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIFF) begin
      d_r <= x_ext - 17'(anc_q.split);
    end
    if (sig_rsp.vld) begin
      p_r <= sig_rsp.p;
    end
    if (state_r == ST_LEAF_MUL) begin
      prod_r <= 34'(leaf_q_vld ? leaf_q : ONE_Q16) * 34'(p_r);
    end
  end

  assign sig_req.vld  = (state_r == ST_SIG_GO);
  assign sig_req.d    = d_r;
  assign sig_req.left = anc_q.left;

  stlp_sigmoid u_sigmoid (
    .clk     (clk),
    .rst_n   (rst_n),
    .inv_tau (inv_tau_r),
    .req     (sig_req),
    .rsp     (sig_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    emit_wait_nxt = 1'b0;
    n_ent_nxt     = n_ent_r;
    n_leaf_nxt    = n_leaf_r;
    ent_nxt       = ent_r;
    leaf_nxt      = leaf_r;
    case (state_r)
      ST_IDLE: begin
        if (emit_wait_r) begin
          if (leaf_r == n_leaf_r) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EMIT_RD;
          end
        end else if (row_start) begin
          n_ent_nxt  = (32'(num_entries_r) > MAX_ENTRIES) ? 7'(MAX_ENTRIES) : num_entries_r;
          n_leaf_nxt = (32'(num_leaves_r) > LEAF_CAP) ? 6'(LEAF_CAP) : num_leaves_r;
          ent_nxt    = 7'd0;
          leaf_nxt   = 6'd0;
          if (n_ent_nxt != 7'd0) begin
            state_nxt = ST_ANC_RD;
          end else if (n_leaf_nxt != 6'd0) begin
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      ST_ANC_RD:   state_nxt = ST_FEAT_RD;
      ST_FEAT_RD:  state_nxt = ST_DIFF;
      ST_DIFF:     state_nxt = ST_SIG_GO;
      ST_SIG_GO:   state_nxt = ST_SIG_WAIT;
      ST_SIG_WAIT: begin
        if (sig_rsp.vld) begin
          if (slot_ok) begin
            state_nxt = ST_LEAF_RD;
          end else begin
            ent_nxt = ent_inc;
            if (ent_inc == n_ent_r) begin
              state_nxt = (n_leaf_r != 6'd0) ? ST_EMIT_RD : ST_IDLE;
            end else begin
              state_nxt = ST_ANC_RD;
            end
          end
        end
      end
      ST_LEAF_RD:  state_nxt = ST_LEAF_MUL;
      ST_LEAF_MUL: state_nxt = ST_LEAF_WR;
      ST_LEAF_WR: begin
        ent_nxt = ent_inc;
        if (ent_inc == n_ent_r) begin
          state_nxt = (n_leaf_r != 6'd0) ? ST_EMIT_RD : ST_IDLE;
        end else begin
          state_nxt = ST_ANC_RD;
        end
      end
      ST_EMIT_RD: begin
        if (out_free) begin
          emit_wait_nxt = 1'b1;
          leaf_nxt      = leaf_r + 6'd1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      emit_wait_r <= 1'b0;
      n_ent_r     <= 7'd0;
      n_leaf_r    <= 6'd0;
      ent_r       <= 7'd0;
      leaf_r      <= 6'd0;
    end else begin
      state_r     <= state_nxt;
      emit_wait_r <= emit_wait_nxt;
      n_ent_r     <= n_ent_nxt;
      n_leaf_r    <= n_leaf_nxt;
      ent_r       <= ent_nxt;
      leaf_r      <= leaf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit_wait_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_wait_r) begin
      out_idx_r  <= 5'(leaf_r - 6'd1);
      out_prob_r <= leaf_q_vld ? leaf_q : ONE_Q16;
      out_last_r <= (leaf_r == n_leaf_r);
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.leaf_index       = out_idx_r;
  assign out_ch.leaf_probability = out_prob_r;
  assign out_ch.last_leaf        = out_last_r;

  `ASSERT_CLK(a_sig_in_wait, sig_rsp.vld |-> state_r == ST_SIG_WAIT, "sigmoid result lost")
  `ASSERT_CLK(a_prod_bound, leaf_wr |-> leaf_new <= ONE_Q16, "leaf product above one")
  `ASSERT_CLK(a_emit_free, emit_wait_r |-> !out_vld_r, "result register overwritten")
  `ASSERT_CLK(a_idx_range, out_vld_r |-> {1'b0, out_idx_r} < n_leaf_r, "leaf index out of range")

endmodule

// ----- rtl/stlp_sigmoid.sv -----
// ----------------------------------------------------------------------------
// stlp_sigmoid
// Three-stage branch probability unit: scaling, table interpolation, branch side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stlp_sigmoid
  import stlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] inv_tau,
  input  sig_req_t    req,
  output sig_rsp_t    rsp
);

  logic        v1_r, v2_r, v3_r;
  logic        neg1_r, left1_r, flip2_r;
  logic [15:0] m1_r;
  logic        sat2_r;
  logic [15:0] base2_r;
  logic [27:0] prod2_r;
  logic [16:0] p3_r;

  logic [16:0] mag;
  logic [32:0] scaled;
  logic [24:0] zq;
  logic [15:0] m_nxt;
  logic [3:0]  ti;
  logic [15:0] diff;
  logic [16:0] s_val;
  logic [16:0] p_nxt;

  always_comb begin
    mag    = req.d[16] ? 17'(-req.d) : 17'(req.d);
    scaled = 33'(mag) * 33'(inv_tau);
    zq     = scaled[32:8];
    m_nxt  = (zq > 25'd32768) ? 16'd32768 : zq[15:0];
    ti     = m1_r[15:12];
    diff   = sig_tab(ti + 4'd1) - sig_tab(ti);
    s_val  = 17'(base2_r) + 17'((prod2_r + 28'd2048) >> 12);
    p_nxt  = flip2_r ? (ONE_Q16 - s_val) : s_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= req.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    neg1_r  <= req.d[16];
    left1_r <= req.left;
    m1_r    <= m_nxt;
    flip2_r <= neg1_r ^ ~left1_r;
    sat2_r  <= (ti >= 4'd8);
    base2_r <= sig_tab(ti);
    prod2_r <= (ti >= 4'd8) ? 28'd0 : 28'(diff) * 28'(m1_r[11:0]);
    p3_r    <= sat2_r ? (flip2_r ? (ONE_Q16 - 17'(sig_tab(4'd8))) : 17'(sig_tab(4'd8)))
                      : p_nxt;
  end

  assign rsp.vld = v3_r;
  assign rsp.p   = p3_r;

  `ASSERT_CLK(a_p_range, v3_r |-> p3_r <= ONE_Q16, "branch probability above one")
  `ASSERT_CLK(a_latency, req.vld |-> ##3 v3_r, "branch probability latency broken")

endmodule

// ----- sim/stlp_tb_checker.sv -----
// ----------------------------------------------------------------------------
// stlp_tb_checker
// Watches both channels of the soft tree leaf probability block, keeps its
// own copy of the ancestor table, feature row and registers, predicts the
// leaf probabilities of every row and compares them with the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stlp_tb_checker
  import stlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  stlp_in_if.sink     in_ch,
  stlp_out_if.sink    out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending_leaves,
  output int          leaves_seen,
  output int          rows_seen
);

  typedef struct packed {
    logic [4:0]  leaf;
    logic [16:0] prob;
    logic        last;
  } leaf_res_t;

  localparam logic [16:0] SAT_Q16 = 17'd65514;

  anc_t               tree_tab [64];
  logic signed [15:0] row_vals [64];
  logic [15:0]        inv_tau_q;
  logic [6:0]         n_entries_q;
  logic [5:0]         n_leaves_q;
  leaf_res_t          leaf_queue [$];

  assign pending_leaves = leaf_queue.size();

  function automatic logic [16:0] branch_sigmoid(logic signed [16:0] d, logic [15:0] itau);
    logic [16:0] mag;
    logic [40:0] m;
    logic [3:0]  i;
    logic [11:0] f;
    logic [16:0] lo, hi, s;
    mag = d[16] ? 17'(-d) : 17'(d);
    m = ({24'd0, mag} * {25'd0, itau}) >> 8;
    if (m > 41'd32768) m = 41'd32768;
    i = m[15:12];
    f = m[11:0];
    if (i >= 4'd8) s = SAT_Q16;
    else begin
      lo = 17'(sig_tab_value(i));
      hi = 17'(sig_tab_value(i + 4'd1));
      s = lo + 17'((32'(hi - lo) * f + 32'd2048) >> 12);
    end
    return d[16] ? ONE_Q16 - s : s;
  endfunction

  function automatic logic [15:0] sig_tab_value(logic [3:0] k);
    logic [15:0] t [9] = '{16'd32768, 16'd47911, 16'd57724, 16'd62428, 16'd64357,
                           16'd65097, 16'd65374, 16'd65476, 16'd65514};
    return t[k];
  endfunction

  task automatic predict_row();
    logic [16:0] prod [32];
    int n_e, n_l;
    logic signed [16:0] d;
    logic [16:0] s, p;
    leaf_res_t r;
    n_e = (n_entries_q > 64) ? 64 : n_entries_q;
    n_l = (n_leaves_q > 32) ? 32 : n_leaves_q;
    foreach (prod[k]) prod[k] = ONE_Q16;
    for (int e = 0; e < n_e; e++) begin
      d = 17'(row_vals[tree_tab[e].feat]) - 17'(tree_tab[e].split);
      s = branch_sigmoid(d, inv_tau_q);
      p = tree_tab[e].left ? s : ONE_Q16 - s;
      prod[tree_tab[e].slot] = 17'((34'(prod[tree_tab[e].slot]) * p + 34'd32768) >> 16);
    end
    for (int k = 0; k < n_l; k++) begin
      r.leaf = 5'(k);
      r.prob = prod[k];
      r.last = (k + 1 == n_l);
      leaf_queue.push_back(r);
    end
  endtask

  always_ff @(posedge clk) begin
    leaf_res_t want;
    if (!rst_n) begin
      inv_tau_q   <= 16'd256;
      n_entries_q <= 7'd1;
      n_leaves_q  <= 6'd1;
      fail_count  <= 0;
      leaves_seen <= 0;
      rows_seen   <= 0;
      leaf_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INV_TAU:     inv_tau_q <= cfg_data;
          CFG_NUM_ENTRIES: n_entries_q <= cfg_data[6:0];
          CFG_NUM_LEAVES:  n_leaves_q <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        leaves_seen <= leaves_seen + 1;
        if (leaf_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("Unexpected leaf transfer: leaf %0d prob %0d",
                                        out_ch.leaf_index, out_ch.leaf_probability);
        end else begin
          want = leaf_queue.pop_front();
          if (want.leaf !== out_ch.leaf_index || want.prob !== out_ch.leaf_probability ||
              want.last !== out_ch.last_leaf) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("Leaf mismatch: expected leaf %0d prob %0d last %0d, got %0d %0d %0d",
                       want.leaf, want.prob, want.last, out_ch.leaf_index,
                       out_ch.leaf_probability, out_ch.last_leaf);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode == MODE_LOAD) begin
          tree_tab[in_ch.entry_index] = '{in_ch.leaf_slot, in_ch.split_value,
                                          in_ch.goes_left, in_ch.split_feature};
        end else begin
          row_vals[in_ch.feature_index] = in_ch.feature_value;
          if (in_ch.last_feature) begin
            rows_seen <= rows_seen + 1;
            predict_row();
          end
        end
      end
    end
  end

endmodule

// ----- sim/tb_soft_tree_leaf_probabilities.sv -----
// ----------------------------------------------------------------------------
// tb_soft_tree_leaf_probabilities
// Drives ancestor loads, feature rows and register settings into the soft
// tree leaf probability block under random idling on both channels; a
// checker module predicts and compares every leaf probability.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_soft_tree_leaf_probabilities;
  import stlp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_INV_TAU;
  logic [15:0] cfg_data = '0;
  int          fail_count, pending_leaves, leaves_seen, rows_seen;
  int          cycle_count = 0;
  int          items_sent = 0;
  bit          calm_phase = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;

  stlp_in_if  in_ch ();
  stlp_out_if out_ch ();

  soft_tree_leaf_probabilities u_dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we, .cfg_index, .cfg_data
  );

  stlp_tb_checker u_checker (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.sink),
    .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending_leaves, .leaves_seen, .rows_seen
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_LOAD;
    in_ch.entry_index = '0;
    in_ch.leaf_slot = '0;
    in_ch.split_value = '0;
    in_ch.goes_left = 1'b0;
    in_ch.split_feature = '0;
    in_ch.feature_index = '0;
    in_ch.feature_value = '0;
    in_ch.last_feature = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The result side stalls in random bursts until the calm phase.
  always @(posedge clk) begin
    if (!rst_n || calm_phase) begin
      out_ch.ready <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ch.ready <= (out_stall == 1);
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= $urandom_range(1, 19);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic send_item(logic mode, logic [5:0] ent, logic [4:0] slot, logic [15:0] split,
                           logic left, logic [5:0] sfeat, logic [5:0] fidx,
                           logic [15:0] fval, logic last);
    if (!calm_phase && in_gap == 0 && $urandom_range(0, 7) == 0)
      in_gap = $urandom_range(1, 19);
    while (in_gap > 0) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      in_gap--;
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.entry_index <= ent;
    in_ch.leaf_slot <= slot;
    in_ch.split_value <= split;
    in_ch.goes_left <= left;
    in_ch.split_feature <= sfeat;
    in_ch.feature_index <= fidx;
    in_ch.feature_value <= fval;
    in_ch.last_feature <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic load_entry(int e, int n_leaf);
    send_item(MODE_LOAD, 6'(e), 5'($urandom_range(0, n_leaf - 1)), 16'($urandom),
              1'($urandom), 6'($urandom_range(0, 63)), 6'($urandom), 16'($urandom),
              1'($urandom));
  endtask

  task automatic send_row(int n_feat);
    for (int f = 0; f < n_feat; f++)
      send_item(MODE_FEATURE, 6'($urandom), 5'($urandom), 16'($urandom), 1'($urandom),
                6'($urandom), 6'(f), 16'($urandom), f == n_feat - 1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_leaves != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic setup(logic [15:0] itau, int n_e, int n_l);
    write_reg(CFG_INV_TAU, itau);
    write_reg(CFG_NUM_ENTRIES, 16'(n_e));
    write_reg(CFG_NUM_LEAVES, 16'(n_l));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n_e, n_l;
    int itau_pick [5] = '{1, 256, 4096, 65535, 0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all table slots and all features are written before any use.
    setup(16'd65535, 64, 32);
    for (int e = 0; e < 64; e++)
      send_item(MODE_LOAD, 6'(e), 5'(e % 32), (e % 2) ? 16'h8000 : 16'h7fff, 1'(e[1]),
                6'(63 - e), '0, '0, 1'b0);
    send_item(MODE_FEATURE, '0, '0, '0, 1'b0, '0, 6'd63, 16'h7fff, 1'b0);
    send_item(MODE_FEATURE, '0, '0, '0, 1'b0, '0, 6'd0, 16'h8000, 1'b0);
    for (int f = 1; f < 63; f++)
      send_item(MODE_FEATURE, '0, '0, '0, 1'b0, '0, 6'(f), 16'($urandom), 1'b0);
    send_item(MODE_FEATURE, '0, '0, '0, 1'b0, '0, 6'd5, 16'h0000, 1'b1);
    drain();
    setup(16'd0, 1, 1);
    send_row(1);
    drain();
    setup(16'd1, 0, 0);
    send_row(1);
    drain();
    setup(16'd256, 3, 32);
    send_row(2);
    drain();

    // Random phases of rows with varied registers.
    for (int ph = 0; items_sent < 210; ph++) begin
      n_e = (ph % 4 == 0) ? 64 : $urandom_range(1, 12);
      n_l = (ph % 5 == 0) ? 32 : $urandom_range(1, 8);
      if (items_sent >= 190) calm_phase = 1'b1;
      setup((ph % 3 == 0) ? 16'(itau_pick[ph % 5]) : 16'($urandom), n_e, n_l);
      for (int e = 0; e < n_e; e++) load_entry(e, n_l);
      repeat ($urandom_range(1, 3)) send_row($urandom_range(1, 6));
      drain();
    end

    $display("Covered %0d input transfers, %0d rows, %0d leaf transfers.",
             items_sent, rows_seen, leaves_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
